// ----- rtl/hk_pkg.sv -----
// Shared constants for the top-k smallest heap unit.
// No dependencies; compiled first.
package hk_pkg;

    localparam int MAX_KEEP_DEF  = 64;
    localparam int DIST_BITS_DEF = 48;
    localparam int TAG_BITS_DEF  = 16;

    localparam int KEEP_W   = 7;   // keep_count register width
    localparam int ORD_BITS = 16;  // arrival number width
    localparam int RANK_W   = 6;   // out_rank width

    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd5;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

// ----- rtl/hk_cand_if.sv -----
// Valid/ready channels of the top-k heap unit: candidate input and result output.
// Depends on hk_pkg.
interface hk_cand_if #(
    parameter int DIST_BITS = hk_pkg::DIST_BITS_DEF,
    parameter int TAG_BITS  = hk_pkg::TAG_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [DIST_BITS-1:0] cand_distance;
    logic [TAG_BITS-1:0]  cand_tag;

    modport source (output valid, command, cand_distance, cand_tag, input ready);
    modport sink   (input valid, command, cand_distance, cand_tag, output ready);
endinterface

interface hk_res_if #(
    parameter int DIST_BITS = hk_pkg::DIST_BITS_DEF,
    parameter int TAG_BITS  = hk_pkg::TAG_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [TAG_BITS-1:0]       out_tag;
    logic [DIST_BITS-1:0]      out_distance;
    logic [hk_pkg::RANK_W-1:0] out_rank;
    logic                      last;

    modport source (output valid, found, out_tag, out_distance, out_rank, last, input ready);
    modport sink   (input valid, found, out_tag, out_distance, out_rank, last, output ready);
endinterface

// ----- rtl/top_k_smallest_heap_unit.sv -----
// Top level of the top-k smallest heap unit: keep_count register, heap
// sequencer and entry store. Depends on hk_pkg, hk_cand_if, hk_res_if, hk_mem, hk_core.
//
//  channel | dir | fields
//  cand    | in  | command, cand_distance, cand_tag
//  result  | out | found, out_tag, out_distance, out_rank, last
//  cfg     | in  | cfg_we, cfg_data (keep_count)
//
// Append: the entry sifts up; each parent is read and compared, and moves down if smaller.
// Top replace: the item is compared against the top; if taken, it sifts down from the root.
// Drain of n: n-1 sort steps of root to tail plus a sift-down, then the results in order.
// Empty drain gives one not-found result. The store serves one read per cycle, registered.
// Reset clears counters and control; the store needs no clearing.
// One item at a time; a stalled result only stalls the drain readout.
module top_k_smallest_heap_unit #(
    parameter int MAX_KEEP  = hk_pkg::MAX_KEEP_DEF,
    parameter int DIST_BITS = hk_pkg::DIST_BITS_DEF,
    parameter int TAG_BITS  = hk_pkg::TAG_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    hk_cand_if.sink                   cand,
    hk_res_if.source                  result,
    input  logic                      cfg_we,
    input  logic [hk_pkg::KEEP_W-1:0] cfg_data
);
    import hk_pkg::*;

    localparam int ADDR_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W  = $clog2(MAX_KEEP + 1);
    localparam int ENT_W  = DIST_BITS + ORD_BITS + TAG_BITS;

    logic [KEEP_W-1:0] keep_count_reg;
    logic [CNT_W-1:0]  keep_eff;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [ENT_W-1:0]  mem_wdata, mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_RESET;
        end
        else if (cfg_we)
        begin
            keep_count_reg <= cfg_data;
        end
    end

    // zero keeps one, oversize clamps to the store depth
    always_comb
    begin
        if (keep_count_reg == '0)
        begin
            keep_eff = CNT_W'(1);
        end
        else if (10'(keep_count_reg) > 10'(MAX_KEEP))
        begin
            keep_eff = CNT_W'(MAX_KEEP);
        end
        else
        begin
            keep_eff = CNT_W'(keep_count_reg);
        end
    end

    hk_core #(
        .MAX_KEEP  (MAX_KEEP),
        .DIST_BITS (DIST_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cand      (cand),
        .result    (result),
        .keep_eff  (keep_eff),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    hk_mem #(
        .DEPTH (MAX_KEEP),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- rtl/hk_mem.sv -----
// Heap entry store: one write port, one read port, registered read data.
// No package dependencies.
module hk_mem #(
    parameter int  DEPTH = 64,
    parameter int  WIDTH = 80,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
        // data holds while no read is issued
        if (re)
        begin
            rdata_reg <= ram[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/hk_core.sv -----
// Heap sequencer: sift-up on append, sift-down on top replace, in-place
// heapsort and readout on drain. Depends on hk_pkg, hk_cand_if, hk_res_if.
module hk_core #(
    parameter int  MAX_KEEP  = hk_pkg::MAX_KEEP_DEF,
    parameter int  DIST_BITS = hk_pkg::DIST_BITS_DEF,
    parameter int  TAG_BITS  = hk_pkg::TAG_BITS_DEF,
    localparam int ADDR_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1,
    localparam int CNT_W     = $clog2(MAX_KEEP + 1),
    localparam int ENT_W     = DIST_BITS + hk_pkg::ORD_BITS + TAG_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    hk_cand_if.sink           cand,
    hk_res_if.source          result,
    input  logic [CNT_W-1:0]  keep_eff,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [ENT_W-1:0]  mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [ENT_W-1:0]  mem_rdata
);
    import hk_pkg::*;

    localparam int IX_W = ADDR_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_CHK, S_UP_CMP, S_TOP_CMP, S_DN_L, S_DN_R, S_DN_CMP,
        S_SORT_RD0, S_SORT_RD1, S_SORT_WR, S_EMIT_RD, S_EMIT_LD, S_OUT_EMPTY
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [ORD_BITS-1:0] arrival_reg, arrival_next;
    logic [ENT_W-1:0]    item_reg, item_next;
    logic [ENT_W-1:0]    side_reg, side_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]   end_reg, end_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]   last_idx_reg, last_idx_next;
    logic                sorting_reg, sorting_next;
    logic                has_r_reg, has_r_next;

    logic                 res_valid_reg, res_valid_next;
    logic                 res_found_reg, res_found_next;
    logic [TAG_BITS-1:0]  res_tag_reg, res_tag_next;
    logic [DIST_BITS-1:0] res_dist_reg, res_dist_next;
    logic [RANK_W-1:0]    res_rank_reg, res_rank_next;
    logic                 res_last_reg, res_last_next;

    logic [IX_W-1:0]   l_idx, r_idx, size_x;
    logic [ADDR_W-1:0] parent;
    logic              out_free;

    assign l_idx    = (IX_W'(pos_reg) << 1) + IX_W'(1);
    assign r_idx    = l_idx + IX_W'(1);
    assign size_x   = IX_W'(size_reg);
    assign parent   = (pos_reg - ADDR_W'(1)) >> 1;
    assign out_free = !res_valid_reg || result.ready;

    assign cand.ready          = (state_reg == S_IDLE);
    assign result.valid        = res_valid_reg;
    assign result.found        = res_found_reg;
    assign result.out_tag      = res_tag_reg;
    assign result.out_distance = res_dist_reg;
    assign result.out_rank     = res_rank_reg;
    assign result.last         = res_last_reg;

    always_comb
    begin
        logic             finish_sift;
        logic [ENT_W-1:0] big;
        logic [ADDR_W-1:0] big_pos;

        finish_sift    = 1'b0;
        big            = side_reg;
        big_pos        = ADDR_W'(l_idx);
        state_next     = state_reg;
        fill_next      = fill_reg;
        arrival_next   = arrival_reg;
        item_next      = item_reg;
        side_next      = side_reg;
        pos_next       = pos_reg;
        size_next      = size_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        sorting_next   = sorting_reg;
        has_r_next     = has_r_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_found_next = res_found_reg;
        res_tag_next   = res_tag_reg;
        res_dist_next  = res_dist_reg;
        res_rank_next  = res_rank_reg;
        res_last_next  = res_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = item_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cand.valid)
                begin
                    if (cand.command == CMD_PUSH)
                    begin
                        item_next = {cand.cand_distance, arrival_reg, cand.cand_tag};
                        if (arrival_reg != {ORD_BITS{1'b1}})
                        begin
                            arrival_next = arrival_reg + ORD_BITS'(1);
                        end
                        if (fill_reg < keep_eff)
                        begin
                            pos_next   = ADDR_W'(fill_reg);
                            fill_next  = fill_reg + CNT_W'(1);
                            state_next = S_UP_CHK;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = S_TOP_CMP;
                        end
                    end
                    else
                    begin
                        arrival_next  = '0;
                        fill_next     = '0;
                        idx_next      = '0;
                        last_idx_next = ADDR_W'(fill_reg - CNT_W'(1));
                        end_next      = ADDR_W'(fill_reg - CNT_W'(1));
                        if (fill_reg == '0)
                        begin
                            state_next = S_OUT_EMPTY;
                        end
                        else if (fill_reg == CNT_W'(1))
                        begin
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            sorting_next = 1'b1;
                            state_next   = S_SORT_RD0;
                        end
                    end
                end
            end

            S_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (item_reg > mem_rdata)
                begin
                    // parent moves down into the hole
                    mem_wdata  = mem_rdata;
                    pos_next   = parent;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_TOP_CMP:
            begin
                if (item_reg[ENT_W-1 -: DIST_BITS] < mem_rdata[ENT_W-1 -: DIST_BITS])
                begin
                    pos_next   = '0;
                    size_next  = fill_reg;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_DN_L:
            begin
                if (l_idx >= size_x)
                begin
                    mem_we      = 1'b1;
                    finish_sift = 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(l_idx);
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                side_next = mem_rdata;
                if (r_idx < size_x)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(r_idx);
                    has_r_next = 1'b1;
                end
                else
                begin
                    has_r_next = 1'b0;
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                if (has_r_reg && (mem_rdata > side_reg))
                begin
                    big     = mem_rdata;
                    big_pos = ADDR_W'(r_idx);
                end
                mem_we = 1'b1;
                if (big > item_reg)
                begin
                    mem_wdata  = big;
                    pos_next   = big_pos;
                    state_next = S_DN_L;
                end
                else
                begin
                    finish_sift = 1'b1;
                end
            end

            S_SORT_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_SORT_RD1;
            end

            S_SORT_RD1:
            begin
                side_next  = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = end_reg;
                state_next = S_SORT_WR;
            end

            S_SORT_WR:
            begin
                // current max goes to the tail, tail entry sifts down from the root
                mem_we     = 1'b1;
                mem_waddr  = end_reg;
                mem_wdata  = side_reg;
                item_next  = mem_rdata;
                pos_next   = '0;
                size_next  = CNT_W'(end_reg);
                state_next = S_DN_L;
            end

            S_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_found_next = 1'b1;
                    res_tag_next   = mem_rdata[TAG_BITS-1:0];
                    res_dist_next  = mem_rdata[ENT_W-1 -: DIST_BITS];
                    res_rank_next  = RANK_W'(idx_reg);
                    res_last_next  = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_OUT_EMPTY:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_found_next = 1'b0;
                    res_tag_next   = '0;
                    res_dist_next  = '0;
                    res_rank_next  = '0;
                    res_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish_sift)
        begin
            if (!sorting_reg)
            begin
                state_next = S_IDLE;
            end
            else if (end_reg == ADDR_W'(1))
            begin
                sorting_next = 1'b0;
                state_next   = S_EMIT_RD;
            end
            else
            begin
                end_next   = end_reg - ADDR_W'(1);
                state_next = S_SORT_RD0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            arrival_reg   <= '0;
            sorting_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            arrival_reg   <= arrival_next;
            sorting_reg   <= sorting_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        side_reg     <= side_next;
        pos_reg      <= pos_next;
        size_reg     <= size_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        has_r_reg    <= has_r_next;
        res_found_reg <= res_found_next;
        res_tag_reg  <= res_tag_next;
        res_dist_reg <= res_dist_next;
        res_rank_reg <= res_rank_next;
        res_last_reg <= res_last_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_KEEP))
        else $error("fill count above store depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("read and write of the same entry in one cycle");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cand.valid && cand.ready && cand.command == CMD_DRAIN
        |=> fill_reg == '0 && arrival_reg == '0)
        else $error("drain did not clear counters");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cand.valid && cand.ready && cand.command == CMD_PUSH && fill_reg < keep_eff
        |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("append did not grow the heap");

    a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DN_L |-> CNT_W'(pos_reg) < size_reg)
        else $error("sift-down position outside heap");

endmodule

// ----- test/tb_top_k_smallest_heap_unit.sv -----
// Testbench for top_k_smallest_heap_unit: directed table, then random push/drain sets.
// Depends on hk_pkg, hk_cand_if, hk_res_if and the unit itself; scores with its own heap model.
`timescale 1ns / 1ps

module tb_top_k_smallest_heap_unit;

    import hk_pkg::*;

    localparam int DW = DIST_BITS_DEF;
    localparam int TW = TAG_BITS_DEF;
    localparam int MK = MAX_KEEP_DEF;

    localparam logic [DW-1:0] DMAX = {DW{1'b1}};
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};
    localparam logic [ORD_BITS-1:0] ARRIVAL_MAX = {ORD_BITS{1'b1}};

    localparam int QUIET_CYCLES = 80;        // longest push still in flight
    localparam int STALL_CYCLES = 400;       // long receiver hold-off
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef enum int {RECV_SLOW, SEND_SLOW, NO_IDLE} idle_mode_t;

    typedef struct packed {
        logic              found;
        logic [TW-1:0]     tag;
        logic [DW-1:0]     distance;
        logic [RANK_W-1:0] rank;
        logic              last;
    } hk_result_t;

    typedef struct packed {
        logic          cmd;
        logic [DW-1:0] distance;
        logic [TW-1:0] tag;
        logic          typed;
        hk_result_t    want;
    } dir_row_t;

    localparam hk_result_t NO_RESULT = '0;
    localparam hk_result_t EMPTY_DRAIN = '{1'b0, '0, '0, '0, 1'b1};

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{CMD_DRAIN, '0, '0, 1'b1, EMPTY_DRAIN},
        '{CMD_PUSH, DMAX, TMAX, 1'b0, NO_RESULT},
        '{CMD_DRAIN, '0, '0, 1'b1, '{1'b1, TMAX, DMAX, '0, 1'b1}},
        '{CMD_PUSH, '0, '0, 1'b0, NO_RESULT},
        '{CMD_DRAIN, '0, '0, 1'b1, '{1'b1, '0, '0, '0, 1'b1}},
        // fill five, then replace the top and try equal distances
        '{CMD_PUSH, 48'd100, 16'h0001, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'd50, 16'h0002, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'd100, 16'h0003, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'd200, 16'h0004, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'd50, 16'h0005, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'd100, 16'h0006, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'd100, 16'h0007, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'd10, 16'h0008, 1'b0, NO_RESULT},
        '{CMD_DRAIN, '0, '0, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'hAAAA_AAAA_AAAA, 16'hAAAA, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'h5555_5555_5555, 16'h5555, 1'b0, NO_RESULT},
        '{CMD_PUSH, 48'h5555_5555_5555, 16'h0F0F, 1'b0, NO_RESULT},
        '{CMD_DRAIN, '0, '0, 1'b0, NO_RESULT},
        '{CMD_DRAIN, '0, '0, 1'b1, EMPTY_DRAIN},
        '{CMD_PUSH, DMAX, '0, 1'b0, NO_RESULT},
        '{CMD_DRAIN, '0, '0, 1'b0, NO_RESULT}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [KEEP_W-1:0] cfg_data;

    hk_cand_if cand_ch ();
    hk_res_if  res_ch ();

    top_k_smallest_heap_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cand     (cand_ch),
        .result   (res_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // heap model state
    logic [DW-1:0]       kept_dist [MK];
    logic [TW-1:0]       kept_tag [MK];
    logic [ORD_BITS-1:0] kept_arrival [MK];
    int                  kept_fill;
    logic [ORD_BITS-1:0] arrival_num;
    logic [KEEP_W-1:0]   keep_reg;

    hk_result_t drain_out [$];
    hk_result_t pending_results [$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_token;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // true when slot a orders strictly above slot b
    function automatic bit entry_gt(input int a, input int b);
        if (kept_dist[a] != kept_dist[b]) return kept_dist[a] > kept_dist[b];
        if (kept_arrival[a] != kept_arrival[b]) return kept_arrival[a] > kept_arrival[b];
        return kept_tag[a] > kept_tag[b];
    endfunction

    task automatic swap_slots(input int a, input int b);
        logic [DW-1:0]       d;
        logic [TW-1:0]       t;
        logic [ORD_BITS-1:0] o;
        d = kept_dist[a];    kept_dist[a] = kept_dist[b];       kept_dist[b] = d;
        t = kept_tag[a];     kept_tag[a] = kept_tag[b];         kept_tag[b] = t;
        o = kept_arrival[a]; kept_arrival[a] = kept_arrival[b]; kept_arrival[b] = o;
    endtask

    // Advances the heap model by one item; a drain leaves its sorted results in drain_out.
    task automatic heap_predict(input logic cmd, input logic [DW-1:0] d,
                                input logic [TW-1:0] t);
        int         k, pos, parent, l, r, big, n, rk, i, best;
        bit         taken [MK];
        hk_result_t res;
        drain_out.delete();
        if (cmd == CMD_PUSH)
        begin
            k = (keep_reg == 0) ? 1 : ((keep_reg > MK) ? MK : int'(keep_reg));
            if (kept_fill < k)
            begin
                pos = kept_fill;
                kept_dist[pos] = d; kept_tag[pos] = t; kept_arrival[pos] = arrival_num;
                kept_fill++;
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!entry_gt(pos, parent)) break;
                    swap_slots(pos, parent);
                    pos = parent;
                end
            end
            else if (kept_fill > 0 && d < kept_dist[0])
            begin
                kept_dist[0] = d; kept_tag[0] = t; kept_arrival[0] = arrival_num;
                pos = 0;
                forever
                begin
                    l = 2 * pos + 1;
                    r = l + 1;
                    big = pos;
                    if (l < kept_fill && entry_gt(l, big)) big = l;
                    if (r < kept_fill && entry_gt(r, big)) big = r;
                    if (big == pos) break;
                    swap_slots(pos, big);
                    pos = big;
                end
            end
            if (arrival_num != ARRIVAL_MAX) arrival_num++;
        end
        else
        begin
            if (kept_fill == 0)
                drain_out = {drain_out, EMPTY_DRAIN};
            n = kept_fill;
            foreach (taken[j]) taken[j] = 1'b0;
            for (rk = 0; rk < n; rk++)
            begin
                best = -1;
                for (i = 0; i < n; i++)
                    if (!taken[i] && (best < 0 || entry_gt(best, i))) best = i;
                taken[best] = 1'b1;
                res.found    = 1'b1;
                res.tag      = kept_tag[best];
                res.distance = kept_dist[best];
                res.rank     = rk[RANK_W-1:0];
                res.last     = (rk == n - 1);
                drain_out = {drain_out, res};
            end
            kept_fill = 0;
            arrival_num = '0;
        end
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            RECV_SLOW: begin send_idle_pct = 28; recv_idle_pct = 58; end
            SEND_SLOW: begin send_idle_pct = 58; recv_idle_pct = 28; end
            default:   begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    // Drives the item from the falling clock and returns once the unit has taken it.
    // valid stays high on return so the next call decides it with a single assignment.
    task automatic send_item(input logic cmd, input logic [DW-1:0] d, input logic [TW-1:0] t,
                             input logic typed, input hk_result_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cand_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cand_ch.valid         <= 1'b1;
        cand_ch.command       <= cmd;
        cand_ch.cand_distance <= d;
        cand_ch.cand_tag      <= t;
        do
            @(posedge clk);
        while (!cand_ch.ready);
        heap_predict(cmd, d, t);
        if (typed)
            pending_results = {pending_results, want};
        else
            pending_results = {pending_results, drain_out};
    endtask

    task automatic sender_stop();
        @(negedge clk);
        cand_ch.valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        keep_reg = v;
    endtask

    // many small values so equal distances come up, plus extremes and full range
    function automatic logic [DW-1:0] rand_dist();
        logic [63:0] wide;
        int          pick;
        pick = $urandom_range(0, 9);
        wide = {$urandom, $urandom};
        case (pick)
            0: return '0;
            1: return DMAX;
            2, 3, 4: return DW'($urandom_range(0, 15));
            5: return DMAX - DW'($urandom_range(0, 3));
            default: return wide[DW-1:0];
        endcase
    endfunction

    task automatic push_burst(input int n, input bit noisy);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(CMD_DRAIN, rand_dist(), TW'($urandom), 1'b0, NO_RESULT);
            send_item(CMD_PUSH, rand_dist(), TW'($urandom), 1'b0, NO_RESULT);
        end
    endtask

    task automatic run_sets(input int n_sets, input int lo, input int hi);
        int s;
        for (s = 0; s < n_sets; s++)
        begin
            push_burst($urandom_range(lo, hi), 1'b1);
            send_item(CMD_DRAIN, rand_dist(), TW'($urandom), 1'b0, NO_RESULT);
        end
    endtask

    task automatic settle_and_keep(input logic [KEEP_W-1:0] v, input idle_mode_t mode);
        sender_stop();
        wait_quiet();
        write_keep(v);
        set_idling(mode);
    endtask

    // receiver: random ready, or a long hold-off when the stimulus asks for one
    initial
    begin : receiver
        int hold_seen;
        hold_seen = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                res_ch.ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        hk_result_t got;
        hk_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.found    = res_ch.found;
            got.tag      = res_ch.out_tag;
            got.distance = res_ch.out_distance;
            got.rank     = res_ch.out_rank;
            got.last     = res_ch.last;
            if (pending_results.size() == 0)
                report_mismatch("unexpected item", 64'(got.tag), 64'(got.distance));
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 64'(got.found), 64'(want.found));
                if (got.tag !== want.tag)
                    report_mismatch("out_tag", 64'(got.tag), 64'(want.tag));
                if (got.distance !== want.distance)
                    report_mismatch("out_distance", 64'(got.distance), 64'(want.distance));
                if (got.rank !== want.rank)
                    report_mismatch("out_rank", 64'(got.rank), 64'(want.rank));
                if (got.last !== want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
        end
    end

    initial
    begin : stimulus
        int i, p;
        error_count = 0;
        hold_token = 0;
        cand_ch.valid = 1'b0;
        cand_ch.command = CMD_PUSH;
        cand_ch.cand_distance = '0;
        cand_ch.cand_tag = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        kept_fill = 0;
        arrival_num = '0;
        keep_reg = KEEP_RESET;
        set_idling(RECV_SLOW);
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TABLE[i].cmd, DIR_TABLE[i].distance, DIR_TABLE[i].tag,
                      DIR_TABLE[i].typed, DIR_TABLE[i].want);

        settle_and_keep(7'd1, RECV_SLOW);
        run_sets(4, 0, 8);

        settle_and_keep(7'd64, SEND_SLOW);
        run_sets(1, 70, 74);

        // zero acts as one, above the store size acts as the store size
        settle_and_keep(7'd0, NO_IDLE);
        run_sets(3, 0, 6);

        settle_and_keep(7'd127, RECV_SLOW);
        run_sets(1, 66, 70);

        // keep count lowered while the store holds more than the new limit
        settle_and_keep(7'd16, SEND_SLOW);
        push_burst(20, 1'b0);
        settle_and_keep(7'd4, SEND_SLOW);
        push_burst(8, 1'b0);
        send_item(CMD_DRAIN, '0, '0, 1'b0, NO_RESULT);

        // receiver stalls during a drain while pushes keep coming
        settle_and_keep(7'd10, NO_IDLE);
        push_burst(10, 1'b0);
        hold_token++;
        send_item(CMD_DRAIN, '0, '0, 1'b0, NO_RESULT);
        push_burst(15, 1'b0);
        send_item(CMD_DRAIN, '0, '0, 1'b0, NO_RESULT);

        for (p = 0; p < 6; p++)
        begin
            settle_and_keep(KEEP_W'($urandom_range(1, 20)), idle_mode_t'(p % 3));
            run_sets(3, 0, 12);
        end

        // equal distances: arrival order decides, a later equal one never replaces the top
        settle_and_keep(7'd2, NO_IDLE);
        send_item(CMD_PUSH, 48'd5, 16'd9, 1'b0, NO_RESULT);
        send_item(CMD_PUSH, 48'd5, 16'd3, 1'b0, NO_RESULT);
        send_item(CMD_PUSH, 48'd5, 16'd1, 1'b0, NO_RESULT);
        send_item(CMD_DRAIN, '0, '0, 1'b0, NO_RESULT);

        sender_stop();
        wait_quiet();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
